@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define IPL_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define IPL_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define IPL_ASSERT(name, prop)
`define IPL_NEVER(name, cond)
`endif

`endif

@@ rtl/ipl_pkg.sv @@
// Shared types and constants of the inverse piecewise-linear lookup.
package ipl_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 16;
    localparam int ENTRY_W     = 2 * WORD_W;
    localparam int CFG_W       = 5;
    localparam int CNT_W       = $clog2(WORD_W);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OUT_INTERP = 2'd0,
        OUT_ABOVE  = 2'd1,
        OUT_BELOW  = 2'd2,
        OUT_NONE   = 2'd3
    } ipl_outcome_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN0,
        S_SCAN,
        S_ARITH
    } ipl_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MUL,
        PH_DIV
    } ipl_phase_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [ENTRY_W-1:0] data;
    } ipl_wr_t;

    typedef struct packed {
        logic              go;
        logic [WORD_W-1:0] num_a;
        logic [WORD_W-1:0] mult;
        logic [WORD_W-1:0] divisor;
    } ipl_arith_req_t;

endpackage

@@ rtl/ipl_table.sv @@
// Breakpoint table memory: one write port, one registered read port.
module ipl_table (
    input  logic                          clk,
    input  ipl_pkg::ipl_wr_t              wr,
    input  logic [ipl_pkg::IDX_W-1:0]     rd_addr,
    output logic [ipl_pkg::ENTRY_W-1:0]   rd_data
);
    import ipl_pkg::*;

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ipl_muldiv.sv @@
// Bit-serial multiply then restoring divide: q = (a * m) / d, with a <= d.
module ipl_muldiv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ipl_pkg::ipl_arith_req_t      req,
    output logic                         done,
    output logic [ipl_pkg::WORD_W-1:0]   quotient
);
    import ipl_pkg::*;

`include "assert_macros.svh"

    ipl_phase_t          phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [WORD_W-1:0]   hi_reg, hi_next;
    logic [WORD_W-1:0]   lo_reg, lo_next;
    logic [WORD_W-1:0]   mult_reg, mult_next;
    logic [WORD_W-1:0]   divisor_reg, divisor_next;

    logic [WORD_W:0]     sum;
    logic [WORD_W:0]     trial;
    logic [WORD_W:0]     diff;
    logic                ge;
    logic                last_step;

    // multiply: add multiplicand into the high half, shift right one bit
    assign sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mult_reg} : '0);
    // divide: high half is the partial remainder, low half shifts out / in
    assign trial     = {hi_reg, lo_reg[WORD_W-1]};
    assign diff      = trial - {1'b0, divisor_reg};
    assign ge        = (trial >= {1'b0, divisor_reg});
    assign last_step = (cnt_reg == CNT_W'(WORD_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        mult_reg    <= mult_next;
        divisor_reg <= divisor_next;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        mult_next    = mult_reg;
        divisor_next = divisor_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (req.go)
                begin
                    hi_next      = '0;
                    lo_next      = req.num_a;
                    mult_next    = req.mult;
                    divisor_next = req.divisor;
                    cnt_next     = '0;
                    phase_next   = PH_MUL;
                end
            end
            PH_MUL:
            begin
                hi_next  = sum[WORD_W:1];
                lo_next  = {sum[0], lo_reg[WORD_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    cnt_next   = '0;
                    phase_next = PH_DIV;
                end
            end
            PH_DIV:
            begin
                hi_next  = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
                lo_next  = {lo_reg[WORD_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

    `IPL_NEVER(a_go_when_busy, req.go && phase_reg != PH_IDLE)
    `IPL_NEVER(a_zero_divisor, req.go && req.divisor == '0)
    `IPL_NEVER(a_rem_bound, phase_reg == PH_DIV && hi_reg >= divisor_reg)
    `IPL_ASSERT(a_done_to_idle, done_reg |-> phase_reg == PH_IDLE)

endmodule

@@ rtl/inverse_piecewise_linear_lookup_core.sv @@
// Inverse piecewise-linear lookup: top level with the search sequencer.
// Write: no result. Busy drops with the strobe; the next item may be taken then.
// Query: clamped above if above the first entry's y, else clamped below if below the
// last entry's y, else a segment scan; a flat segment or no segment ends it, any other hit
// runs the 16 + 16 step serial multiply/divide, the longest case.
// Asynchronous active-low reset: idle, points_in_use = 2, table contents undefined.
module inverse_piecewise_linear_lookup_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   cmd,
    input  logic [ipl_pkg::IDX_W-1:0]              point_index,
    input  logic [ipl_pkg::WORD_W-1:0]             point_x,
    input  logic [ipl_pkg::WORD_W-1:0]             point_y,
    input  logic [ipl_pkg::WORD_W-1:0]             query_value,
    output logic                                   done,
    output logic [ipl_pkg::WORD_W-1:0]             result_x,
    output logic [1:0]                             outcome,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ipl_pkg::CFG_W-1:0]              points_in_use
);
    import ipl_pkg::*;

`include "assert_macros.svh"

    ipl_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic [WORD_W-1:0]   y_reg, y_next;
    logic [WORD_W-1:0]   x1_reg, x1_next;
    logic [WORD_W-1:0]   y1_reg, y1_next;
    logic                neg_reg, neg_next;
    logic [WORD_W-1:0]   result_x_reg, result_x_next;
    ipl_outcome_t        outcome_reg, outcome_next;
    logic                done_reg, done_next;
    logic [CFG_W-1:0]    points_in_use_reg;

    ipl_wr_t             wr;
    ipl_arith_req_t      req;
    logic [IDX_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic [WORD_W-1:0]   rd_x;
    logic [WORD_W-1:0]   rd_y;
    logic                arith_done;
    logic [WORD_W-1:0]   quotient;
    logic                accept;
    logic [IDX_W-1:0]    last_use;

    ipl_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ipl_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .done     (arith_done),
        .quotient (quotient)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign rd_x      = rd_data[ENTRY_W-1:WORD_W];
    assign rd_y      = rd_data[WORD_W-1:0];

    assign wr.en   = accept && (cmd == CMD_WRITE) && (int'(point_index) < TABLE_DEPTH);
    assign wr.addr = IDX_W'(point_index);
    assign wr.data = {point_x, point_y};

    // used count clamped to 2..depth, held as index of the last entry
    always_comb
    begin
        if (points_in_use_reg < CFG_W'(2))
        begin
            last_use = IDX_W'(1);
        end
        else if (int'(points_in_use_reg) > TABLE_DEPTH)
        begin
            last_use = IDX_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_use = IDX_W'(points_in_use_reg - CFG_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_in_use_reg <= CFG_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            points_in_use_reg <= points_in_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        y_reg        <= y_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        neg_reg      <= neg_next;
        result_x_reg <= result_x_next;
        outcome_reg  <= outcome_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        y_next        = y_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        neg_next      = neg_reg;
        result_x_next = result_x_reg;
        outcome_next  = outcome_reg;
        done_next     = 1'b0;
        rd_addr       = '0;
        req.go        = 1'b0;
        req.num_a     = y1_reg - y_reg;
        req.divisor   = y1_reg - rd_y;
        req.mult      = (rd_x >= x1_reg) ? (rd_x - x1_reg) : (x1_reg - rd_x);
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == CMD_QUERY))
                begin
                    y_next     = query_value;
                    last_next  = last_use;
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (y_reg > rd_y)
                begin
                    result_x_next = rd_x;
                    outcome_next  = OUT_ABOVE;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    rd_addr    = last_reg;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (y_reg < rd_y)
                begin
                    result_x_next = rd_x;
                    outcome_next  = OUT_BELOW;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    rd_addr    = '0;
                    state_next = S_SCAN0;
                end
            end
            S_SCAN0:
            begin
                x1_next    = rd_x;
                y1_next    = rd_y;
                rd_addr    = IDX_W'(1);
                idx_next   = IDX_W'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if ((y_reg <= y1_reg) && (y_reg >= rd_y))
                begin
                    if (y1_reg == rd_y)
                    begin
                        result_x_next = x1_reg;
                        outcome_next  = OUT_INTERP;
                        done_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        req.go     = 1'b1;
                        neg_next   = (rd_x < x1_reg);
                        state_next = S_ARITH;
                    end
                end
                else if (idx_reg == last_reg)
                begin
                    result_x_next = '0;
                    outcome_next  = OUT_NONE;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    x1_next  = rd_x;
                    y1_next  = rd_y;
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
            end
            S_ARITH:
            begin
                if (arith_done)
                begin
                    result_x_next = neg_reg ? (x1_reg - quotient) : (x1_reg + quotient);
                    outcome_next  = OUT_INTERP;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done     = done_reg;
    assign result_x = result_x_reg;
    assign outcome  = outcome_reg;

    `IPL_ASSERT(a_done_single, done_reg |=> !done_reg)
    `IPL_ASSERT(a_query_busy, (accept && cmd == CMD_QUERY) |=> busy)
    `IPL_NEVER(a_idx_range, state_reg == S_SCAN && idx_reg > last_reg)
    `IPL_ASSERT(a_arith_owner, arith_done |-> state_reg == S_ARITH)

endmodule
